// ----- rtl/cfe_pkg.sv -----
`default_nettype none
package cfe_pkg;

	localparam int NUM_SLOTS    = 4096;
	localparam int BUCKET_SLOTS = 8;
	localparam int NUM_BUCKETS  = NUM_SLOTS / BUCKET_SLOTS;
	localparam int BKT_W        = $clog2(NUM_BUCKETS);
	localparam int MAX_KICKS    = 100;
	localparam int KICK_W       = $clog2(MAX_KICKS + 1);
	localparam int KEY_BYTES    = 16;
	localparam int KEY_W        = 8 * KEY_BYTES;
	localparam int ROW_W        = 8 * BUCKET_SLOTS;

	localparam logic [31:0] MM_C1     = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2     = 32'h1b873593;
	localparam logic [31:0] MM_N      = 32'he6546b64;
	localparam logic [31:0] MM_F1     = 32'h85ebca6b;
	localparam logic [31:0] MM_F2     = 32'hc2b2ae35;
	localparam logic [31:0] MM_SEED   = 32'h00000003;
	localparam logic [31:0] LFSR_TAPS = 32'h80200003;

	localparam logic [1:0] CFG_BUCKET_COUNT = 2'd0;
	localparam logic [1:0] CFG_RANDOM_SEED  = 2'd1;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_DELETE = 2'd2
	} req_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_FP, S_H1, S_H2, S_CHK1, S_CHK2,
		S_KRD, S_KSWAP, S_KHASH, S_KCHK, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		H_IDLE, H_NEXT, H_K1, H_K2, H_MIX, H_F1, H_F2, H_DIV
	} hstate_t;

	typedef enum logic [0:0] {
		H_FIN_OFF, H_FIN_ON
	} hfin_t;

	typedef struct packed {
		logic        start;
		logic [4:0]  len;
		logic [31:0] xor_val;
	} hreq_t;

	typedef struct packed {
		logic             done;
		logic [BKT_W-1:0] bucket;
	} hres_t;

	localparam logic [7:0] PEARSON [256] = '{
		8'd98,  8'd6,   8'd85,  8'd150, 8'd36,  8'd23,  8'd112, 8'd164,
		8'd135, 8'd207, 8'd169, 8'd5,   8'd26,  8'd64,  8'd165, 8'd219,
		8'd61,  8'd20,  8'd68,  8'd89,  8'd130, 8'd63,  8'd52,  8'd102,
		8'd24,  8'd229, 8'd132, 8'd245, 8'd80,  8'd216, 8'd195, 8'd115,
		8'd90,  8'd168, 8'd156, 8'd203, 8'd177, 8'd120, 8'd2,   8'd190,
		8'd188, 8'd7,   8'd100, 8'd185, 8'd174, 8'd243, 8'd162, 8'd10,
		8'd237, 8'd18,  8'd253, 8'd225, 8'd8,   8'd208, 8'd172, 8'd244,
		8'd255, 8'd126, 8'd101, 8'd79,  8'd145, 8'd235, 8'd228, 8'd121,
		8'd123, 8'd251, 8'd67,  8'd250, 8'd161, 8'd107, 8'd255, 8'd97,
		8'd241, 8'd111, 8'd181, 8'd82,  8'd249, 8'd33,  8'd69,  8'd55,
		8'd59,  8'd153, 8'd29,  8'd9,   8'd213, 8'd167, 8'd84,  8'd93,
		8'd30,  8'd46,  8'd94,  8'd75,  8'd151, 8'd114, 8'd73,  8'd222,
		8'd197, 8'd96,  8'd210, 8'd45,  8'd16,  8'd227, 8'd248, 8'd202,
		8'd51,  8'd152, 8'd252, 8'd125, 8'd81,  8'd206, 8'd215, 8'd186,
		8'd39,  8'd158, 8'd178, 8'd187, 8'd131, 8'd136, 8'd1,   8'd49,
		8'd50,  8'd17,  8'd141, 8'd91,  8'd47,  8'd129, 8'd60,  8'd99,
		8'd154, 8'd35,  8'd86,  8'd171, 8'd105, 8'd34,  8'd38,  8'd200,
		8'd147, 8'd58,  8'd77,  8'd118, 8'd173, 8'd246, 8'd76,  8'd254,
		8'd133, 8'd232, 8'd196, 8'd144, 8'd198, 8'd124, 8'd53,  8'd4,
		8'd108, 8'd74,  8'd223, 8'd234, 8'd134, 8'd230, 8'd157, 8'd139,
		8'd189, 8'd205, 8'd199, 8'd128, 8'd176, 8'd19,  8'd211, 8'd236,
		8'd127, 8'd192, 8'd231, 8'd70,  8'd233, 8'd88,  8'd146, 8'd44,
		8'd183, 8'd201, 8'd22,  8'd83,  8'd13,  8'd214, 8'd116, 8'd109,
		8'd159, 8'd32,  8'd95,  8'd226, 8'd140, 8'd220, 8'd57,  8'd12,
		8'd221, 8'd31,  8'd209, 8'd182, 8'd143, 8'd92,  8'd149, 8'd184,
		8'd148, 8'd62,  8'd113, 8'd65,  8'd37,  8'd27,  8'd106, 8'd166,
		8'd3,   8'd14,  8'd204, 8'd72,  8'd21,  8'd41,  8'd56,  8'd66,
		8'd28,  8'd193, 8'd40,  8'd217, 8'd25,  8'd54,  8'd179, 8'd117,
		8'd238, 8'd87,  8'd240, 8'd155, 8'd180, 8'd170, 8'd242, 8'd212,
		8'd191, 8'd163, 8'd78,  8'd218, 8'd137, 8'd194, 8'd175, 8'd110,
		8'd43,  8'd119, 8'd224, 8'd71,  8'd122, 8'd142, 8'd42,  8'd160,
		8'd104, 8'd48,  8'd247, 8'd103, 8'd15,  8'd11,  8'd138, 8'd239
	};

	function automatic logic [31:0] lfsr_next(input logic [31:0] v);
		logic [31:0] s;
		s = {1'b0, v[31:1]};
		if (v[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/cfe_ram.sv -----
`default_nettype none
module cfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// ----- rtl/cfe_hash.sv -----
`default_nettype none
module cfe_hash import cfe_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hreq_t            req,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic [9:0]       nbkt,
	output hres_t                 res
);

	localparam int DIV_BITS = 32 - $clog2(BUCKET_SLOTS);

	hstate_t st_q, st_d;
	logic [KEY_W-1:0]    key_q;
	logic [4:0]          len_q;
	logic [31:0]         xor_q;
	logic [31:0]         h_q;
	logic [31:0]         t_q;
	logic [2:0]          blk_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [9:0]          rem_q;
	logic [4:0]          cnt_q;
	hfin_t               fin_q;

	logic [2:0]  nb;
	logic [1:0]  rm;
	logic        full;
	logic        more;
	logic [31:0] word;
	logic [31:0] mask;
	logic [31:0] k_in;
	logic [31:0] k1_p;
	logic [31:0] t_rot;
	logic [31:0] k2_p;
	logic [31:0] hx;
	logic [31:0] hrot;
	logic [31:0] mix_h;
	logic [31:0] f1_x;
	logic [31:0] f1_p;
	logic [31:0] f2_p;
	logic [31:0] hfin;
	logic [10:0] r11;
	logic [10:0] rsub;
	logic [9:0]  rem_d;

	assign nb    = len_q[4:2];
	assign rm    = len_q[1:0];
	assign full  = blk_q < nb;
	assign more  = full || (blk_q == nb && rm != 2'd0);
	assign word  = key_q[32*blk_q[1:0] +: 32];
	assign mask  = (rm == 2'd1) ? 32'h000000ff : (rm == 2'd2) ? 32'h0000ffff : 32'h00ffffff;
	assign k_in  = full ? word : (word & mask);
	assign k1_p  = k_in * MM_C1;
	assign t_rot = {t_q[16:0], t_q[31:17]};
	assign k2_p  = t_rot * MM_C2;
	assign hx    = h_q ^ t_q;
	assign hrot  = {hx[18:0], hx[31:19]};
	assign mix_h = {hrot[29:0], 2'b00} + hrot + MM_N;
	assign f1_x  = (h_q ^ {27'd0, len_q}) ^ ((h_q ^ {27'd0, len_q}) >> 16);
	assign f1_p  = f1_x * MM_F1;
	assign f2_p  = (h_q ^ (h_q >> 13)) * MM_F2;
	assign hfin  = h_q ^ (h_q >> 16) ^ xor_q;
	assign r11   = {rem_q, quo_q[DIV_BITS-1]};
	assign rsub  = r11 - {1'b0, nbkt};
	assign rem_d = (r11 >= {1'b0, nbkt}) ? rsub[9:0] : r11[9:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= H_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d       = st_q;
		res.done   = 1'b0;
		res.bucket = rem_q[BKT_W-1:0];
		case (st_q)
			H_IDLE: begin
				if (req.start) begin
					st_d = H_NEXT;
				end
			end
			H_NEXT: st_d = more ? H_K1 : H_F1;
			H_K1:   st_d = H_K2;
			H_K2:   st_d = H_MIX;
			H_MIX:  st_d = full ? H_NEXT : H_F1;
			H_F1:   st_d = H_F2;
			H_F2:   st_d = H_DIV;
			H_DIV: begin
				if (fin_q == H_FIN_ON && cnt_q == 5'(DIV_BITS)) begin
					res.done = 1'b1;
					st_d     = req.start ? H_NEXT : H_IDLE;
				end
			end
			default: st_d = H_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			H_IDLE: begin
				if (req.start) begin
					key_q <= key;
					len_q <= req.len;
					xor_q <= req.xor_val;
					h_q   <= MM_SEED;
					blk_q <= 3'd0;
				end
			end
			H_K1: t_q <= k1_p;
			H_K2: t_q <= k2_p;
			H_MIX: begin
				if (full) begin
					h_q   <= mix_h;
					blk_q <= blk_q + 3'd1;
				end else begin
					h_q <= hx;
				end
			end
			H_F1: h_q <= f1_p;
			H_F2: begin
				h_q   <= f2_p;
				fin_q <= H_FIN_OFF;
			end
			H_DIV: begin
				if (fin_q == H_FIN_OFF) begin
					quo_q <= hfin[31:32-DIV_BITS];
					rem_q <= 10'd0;
					cnt_q <= 5'd0;
					fin_q <= H_FIN_ON;
				end else if (cnt_q != 5'(DIV_BITS)) begin
					rem_q <= rem_d;
					quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
				end else if (req.start) begin
					key_q <= key;
					len_q <= req.len;
					xor_q <= req.xor_val;
					h_q   <= MM_SEED;
					blk_q <= 3'd0;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/cuckoo_filter_engine.sv -----
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    req_type, key_low, key_high, key_len
// out      output     out_valid/out_ready  success
// cfg      input      cfg_we               cfg_index, cfg_data
//
// one item at a time; after reset all 512 table rows are cleared
// lookup/delete: two hash passes, each ending in a remainder loop over the
// top 29 hash bits, plus up to two bucket row reads
// insert with evictions: one more hash pass per kick, up to 100 kicks
// the result holds until out_ready; no new item is taken until then
`default_nettype none
module cuckoo_filter_engine import cfe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [63:0] key_low,
	input  wire logic [63:0] key_high,
	input  wire logic [4:0]  key_len,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             success,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	state_t st_q, st_d;
	logic [BKT_W-1:0]  clr_q;
	logic [9:0]        bc_q;
	logic [31:0]       lfsr_q;
	req_t              req_q;
	logic [KEY_W-1:0]  key_q;
	logic [4:0]        len_q;
	logic [7:0]        fp_q;
	logic [4:0]        pi_q;
	logic [BKT_W-1:0]  b1_q;
	logic [BKT_W-1:0]  b2_q;
	logic [BKT_W-1:0]  cur_q;
	logic [2:0]        slot_q;
	logic [KICK_W-1:0] kick_q;
	logic              ok_q;

	logic              ram_we;
	logic [BKT_W-1:0]  ram_addr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_W-1:0]  ram_rdata;
	hreq_t             hreq;
	logic [KEY_W-1:0]  hkey;
	hres_t             hres;

	logic [9:0]        nbkt;
	logic [4:0]        len_in;
	logic [7:0]        target;
	logic              hit;
	logic [2:0]        hit_slot;
	logic [7:0]        wv;
	logic [ROW_W-1:0]  wr_row;
	logic [ROW_W-1:0]  swap_row;
	logic [7:0]        victim;
	logic [31:0]       draw;
	logic              in_acc;

	assign nbkt   = (bc_q == 10'd0) ? 10'd1 :
		(bc_q > 10'(NUM_BUCKETS)) ? 10'(NUM_BUCKETS) : bc_q;
	assign len_in = (key_len > 5'(KEY_BYTES)) ? 5'(KEY_BYTES) : key_len;
	assign target = (req_q == REQ_INSERT) ? 8'd0 : fp_q;
	assign wv     = (req_q == REQ_INSERT) ? fp_q : 8'd0;
	assign victim = ram_rdata[8*slot_q +: 8];
	assign draw   = lfsr_next(lfsr_q);
	assign in_acc = in_valid && in_ready;

	always_comb begin
		hit      = 1'b0;
		hit_slot = 3'd0;
		for (int i = BUCKET_SLOTS - 1; i >= 0; i--) begin
			if (ram_rdata[8*i +: 8] == target) begin
				hit      = 1'b1;
				hit_slot = 3'(i);
			end
		end
		wr_row   = ram_rdata;
		wr_row[8*hit_slot +: 8] = wv;
		swap_row = ram_rdata;
		swap_row[8*slot_q +: 8] = fp_q;
	end

	cfe_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BUCKETS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	cfe_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.key    (hkey),
		.nbkt   (nbkt),
		.res    (hres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = cur_q;
		ram_wdata = wr_row;
		hreq      = '0;
		hkey      = {{(KEY_W-8){1'b0}}, fp_q};
		case (st_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
				if (clr_q == BKT_W'(NUM_BUCKETS - 1)) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (req_type == REQ_INSERT || req_type == REQ_LOOKUP ||
						req_type == REQ_DELETE) begin
						st_d = S_FP;
					end else begin
						st_d = S_OUT;
					end
				end
			end
			S_FP: begin
				if (pi_q >= len_q) begin
					hreq.start = 1'b1;
					hreq.len   = len_q;
					hkey       = key_q;
					st_d       = S_H1;
				end
			end
			S_H1: begin
				if (hres.done) begin
					hreq.start   = 1'b1;
					hreq.len     = 5'd1;
					hreq.xor_val = 32'(hres.bucket) + 32'd1;
					st_d         = S_H2;
				end
			end
			S_H2: begin
				if (hres.done) begin
					ram_addr = b1_q;
					st_d     = S_CHK1;
				end
			end
			S_CHK1: begin
				if (hit) begin
					ram_we   = (req_q != REQ_LOOKUP);
					ram_addr = b1_q;
					st_d     = S_OUT;
				end else begin
					ram_addr = b2_q;
					st_d     = S_CHK2;
				end
			end
			S_CHK2: begin
				ram_addr = b2_q;
				if (hit) begin
					ram_we = (req_q != REQ_LOOKUP);
					st_d   = S_OUT;
				end else if (req_q == REQ_INSERT) begin
					st_d = S_KRD;
				end else begin
					st_d = S_OUT;
				end
			end
			S_KRD: st_d = S_KSWAP;
			S_KSWAP: begin
				ram_we       = 1'b1;
				ram_wdata    = swap_row;
				hreq.start   = 1'b1;
				hreq.len     = 5'd1;
				hreq.xor_val = 32'(cur_q) + 32'd1;
				hkey         = {{(KEY_W-8){1'b0}}, victim};
				st_d         = S_KHASH;
			end
			S_KHASH: begin
				if (hres.done) begin
					ram_addr = hres.bucket;
					st_d     = S_KCHK;
				end
			end
			S_KCHK: begin
				if (hit) begin
					ram_we = 1'b1;
					st_d   = S_OUT;
				end else if (kick_q == KICK_W'(MAX_KICKS)) begin
					st_d = S_OUT;
				end else begin
					st_d = S_KRD;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	assign success = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			bc_q   <= 10'(NUM_BUCKETS);
			lfsr_q <= 32'd1;
		end else begin
			if (st_q == S_CLEAR) begin
				clr_q <= clr_q + BKT_W'(1);
			end
			if (cfg_we && cfg_index == CFG_BUCKET_COUNT) begin
				bc_q <= cfg_data[9:0];
			end
			if (cfg_we && cfg_index == CFG_RANDOM_SEED) begin
				lfsr_q <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
			end else if ((st_q == S_CHK2 && !hit && req_q == REQ_INSERT) || st_q == S_KRD) begin
				lfsr_q <= draw;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (in_acc) begin
					req_q <= req_t'(req_type);
					key_q <= {key_high, key_low};
					len_q <= len_in;
					fp_q  <= PEARSON[(len_in != 5'd0) ? key_low[7:0] : 8'd0];
					pi_q  <= 5'd1;
					ok_q  <= 1'b0;
				end
			end
			S_FP: begin
				if (pi_q < len_q) begin
					fp_q <= PEARSON[fp_q ^ key_q[8*pi_q[3:0] +: 8]];
					pi_q <= pi_q + 5'd1;
				end
			end
			S_H1: begin
				if (hres.done) begin
					b1_q <= hres.bucket;
				end
			end
			S_H2: begin
				if (hres.done) begin
					b2_q <= hres.bucket;
				end
			end
			S_CHK1: begin
				if (hit) begin
					ok_q <= 1'b1;
				end
			end
			S_CHK2: begin
				if (hit) begin
					ok_q <= 1'b1;
				end else begin
					cur_q  <= draw[0] ? b2_q : b1_q;
					kick_q <= '0;
				end
			end
			S_KRD: slot_q <= draw[2:0];
			S_KSWAP: begin
				fp_q   <= victim;
				kick_q <= kick_q + KICK_W'(1);
			end
			S_KHASH: begin
				if (hres.done) begin
					cur_q <= hres.bucket;
				end
			end
			S_KCHK: begin
				if (hit) begin
					ok_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_ready_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output both open");

	a_hash_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		hres.done |-> (st_q == S_H1 || st_q == S_H2 || st_q == S_KHASH))
		else $error("hash result with nobody waiting");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE || st_q == S_OUT) |-> !ram_we)
		else $error("table write outside an item");

	a_out_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready)
		else $error("not ready after result taken");

endmodule
`default_nettype wire
